@@ src/glr_pkg.sv @@
package glr_pkg;

  localparam int SampleWidth   = 32;
  localparam int InputFracBits = 24;
  localparam int LogTableBits  = 8;
  localparam int TableSize     = 1 << LogTableBits;
  localparam int FracWidth     = 16;
  localparam int IntWidth      = 6;
  localparam int LogWidth      = IntWidth + FracWidth;
  localparam int PosWidth      = $clog2(SampleWidth);
  localparam int CodeWidth     = 16;
  localparam int LevelWidth    = 16;
  localparam int BiasWidth     = LogWidth + 2;

  localparam logic [BiasWidth-1:0] HalfRangeQ16 = BiasWidth'(262144);
  localparam logic [LevelWidth-1:0] LevelReset  = LevelWidth'(16);
  localparam logic [CodeWidth-1:0]  NeutralCode = CodeWidth'(32768);
  localparam logic [CodeWidth-1:0]  MaxCode     = '1;

  typedef logic [TableSize-1:0][FracWidth-1:0] frac_table_t;

  // Entry m holds round(65536 * log2(1 + m / TableSize)), built by a bit-serial
  // log2 of the mantissa held in Q.30: square, and take a one when it reaches 2.
  function automatic frac_table_t build_frac_table();
    frac_table_t tbl;
    logic [63:0] x;
    logic [23:0] acc;
    logic [24:0] rnd;
    for (int m = 0; m < TableSize; m++) begin
      x   = (64'd1 << 30) + (64'(m) << (30 - LogTableBits));
      acc = '0;
      for (int i = 0; i < 24; i++) begin
        x   = (x * x) >> 30;
        acc = {acc[22:0], 1'b0};
        if (x >= (64'd1 << 31)) begin
          x      = x >> 1;
          acc[0] = 1'b1;
        end
      end
      rnd    = 25'(acc) + 25'd128;
      tbl[m] = rnd[FracWidth+7:8];
    end
    return tbl;
  endfunction

  localparam frac_table_t FracTable = build_frac_table();

  function automatic logic [PosWidth-1:0] lead_one_pos(logic [SampleWidth-1:0] x);
    logic [PosWidth-1:0] pos;
    pos = '0;
    for (int i = 0; i < SampleWidth; i++) begin
      if (x[i]) pos = PosWidth'(i);
    end
    return pos;
  endfunction

  // log2 of a nonzero sample in signed Q.16.
  function automatic logic signed [LogWidth-1:0] log2_q16(logic [SampleWidth-1:0] x);
    logic [PosWidth-1:0] pos;
    logic [SampleWidth-1:0] norm;
    logic [LogTableBits-1:0] mant;
    logic signed [IntWidth:0] ipart;
    pos   = lead_one_pos(x);
    norm  = x << (PosWidth'(SampleWidth - 1) - pos);
    mant  = norm[SampleWidth-2 -: LogTableBits];
    ipart = $signed({2'b00, pos}) - (IntWidth+1)'(InputFracBits);
    return $signed({ipart[IntWidth-1:0], FracTable[mant]});
  endfunction

endpackage

@@ src/glr_in_if.sv @@
interface glr_in_if import glr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sdr_sample;
  logic [SampleWidth-1:0] hdr_sample;

  modport source (output valid, output sdr_sample, output hdr_sample, input ready);
  modport sink (input valid, input sdr_sample, input hdr_sample, output ready);
endinterface

@@ src/glr_out_if.sv @@
interface glr_out_if import glr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CodeWidth-1:0] gain_code;
  logic                 ratio_valid;

  modport source (output valid, output gain_code, output ratio_valid, input ready);
  modport sink (input valid, input gain_code, input ratio_valid, output ready);
endinterface

@@ src/gain_map_log2_ratio_unit.sv @@
// Channel   Dir   Payload                      Beat taken when
// samples   in    sdr_sample, hdr_sample       samples.valid && samples.ready
// gains     out   gain_code, ratio_valid       gains.valid && gains.ready
// cfg       in    cfg_wdata (min_level)        cfg_we
//
// Each beat is taken into the input register and then moves on into the
// result register once that is free, where it is offered on gains until it
// is taken; one pair is taken every cycle while the output side keeps up.
// The log2 of both samples, the difference and the clamp are one pass of
// logic between those two registers; the leading-one search, normalizing
// shift and the constant fraction table set its depth.
// Reset empties both registers and sets min_level to 16. When the output
// stalls, the result holds and the input register still fills once more.
module gain_map_log2_ratio_unit
  import glr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LevelWidth-1:0] cfg_wdata,
  glr_in_if.sink                samples,
  glr_out_if.source             gains
);

  logic [LevelWidth-1:0] min_level;

  // Input register stage.
  logic                   s1_valid;
  logic                   s1_valid_next;
  logic [SampleWidth-1:0] s1_sdr;
  logic [SampleWidth-1:0] s1_hdr;

  // Result register stage.
  logic                   out_valid;
  logic                   out_valid_next;
  logic [CodeWidth-1:0]   out_code;
  logic                   out_ratio_valid;

  logic in_accept;
  logic out_free;
  logic out_load;

  logic                          dark;
  logic signed [LogWidth-1:0]    sdr_log;
  logic signed [LogWidth-1:0]    hdr_log;
  logic signed [LogWidth:0]      diff;
  logic signed [BiasWidth-1:0]   biased;
  logic [CodeWidth-1:0]          code;

  // The result register can take a new beat when it is empty or being drained.
  assign out_free      = !out_valid || gains.ready;
  assign out_load      = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign in_accept     = samples.valid && samples.ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_accept) begin
      s1_valid_next = 1'b1;
    end else if (out_load) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (gains.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // A sample at or below min_level (zero always is) gives neutral gain.
  assign dark = (s1_sdr <= SampleWidth'(min_level)) || (s1_hdr <= SampleWidth'(min_level));

  assign sdr_log = log2_q16(s1_sdr);
  assign hdr_log = log2_q16(s1_hdr);
  assign diff    = (LogWidth+1)'(hdr_log) - (LogWidth+1)'(sdr_log);
  assign biased  = BiasWidth'(diff) + $signed(HalfRangeQ16);

  // Shift the biased difference down by three and clamp to the code range:
  // negative gives zero, anything above bit 18 saturates, and a dark pair gives the neutral code.
  always_comb begin
    if (dark) begin
      code = NeutralCode;
    end else if (biased[BiasWidth-1]) begin
      code = '0;
    end else if (|biased[BiasWidth-2:CodeWidth+3]) begin
      code = MaxCode;
    end else begin
      code = biased[CodeWidth+2:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= LevelReset;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_level <= cfg_wdata;
      end
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sdr <= samples.sdr_sample;
      s1_hdr <= samples.hdr_sample;
    end
    if (out_load) begin
      out_code        <= code;
      out_ratio_valid <= !dark;
    end
  end

  assign gains.valid       = out_valid;
  assign gains.gain_code   = out_code;
  assign gains.ratio_valid = out_ratio_valid;

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) rst |=> !gains.valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_dark_neutral: assert property (@(posedge clk) disable iff (rst)
    gains.valid && !gains.ratio_valid |-> gains.gain_code == NeutralCode)
    else $error("dark result without neutral code");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    out_load |=> gains.valid)
    else $error("beat lost between input and result register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_sdr) && $stable(s1_hdr))
    else $error("input register changed while output stalled");
`endif

endmodule
